### design/pressure_sensor_compensation_top_macros.svh
// assertion macros for the pressure sensor compensation block
`ifndef PRESSURE_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psc check failed");

// next-cycle implication
`define PSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psc check failed");

`endif

### design/psc_pkg.sv
// shared types, constants and helpers for the pressure compensation block
package psc_pkg;

    localparam int DIV_W = 32;

    localparam logic [2:0] CFG_AC123 = 3'd0;
    localparam logic [2:0] CFG_AC456 = 3'd1;
    localparam logic [2:0] CFG_B12   = 3'd2;
    localparam logic [2:0] CFG_MCMD  = 3'd3;
    localparam logic [2:0] CFG_OSS   = 3'd4;

    localparam logic [31:0] B6_OFS   = 32'd4000;
    localparam logic [31:0] X3_OFS   = 32'd32768;
    localparam logic [31:0] B7_SCALE = 32'd50000;
    localparam logic [31:0] K_SQ     = 32'd3038;
    localparam logic [31:0] K_LIN    = 32'hFFFF_E343;
    localparam logic [31:0] K_OFS    = 32'd3791;
    localparam logic [17:0] P_MAX    = 18'h3FFFF;

    typedef struct packed {
        logic [31:0] a;
        logic [23:0] up;
        logic        fault;
        logic        neg;
    } t_side;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] den;
        t_side       side;
    } t_div;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

### design/pressure_sensor_compensation_top.sv
// Pressure and temperature compensation pipeline. One sample pair is taken per
// cycle while o_stall is low, and every result passes through three input
// stages, a 32-cell temperature divider, five pressure stages, a 32-cell
// pressure divider and three output stages. A stall on the output holds the
// pipeline stage by stage, so empty stages still fill. Write the coefficients
// only while the pipeline is empty; writes are always taken (o_cfg_ready stays
// high).
module pressure_sensor_compensation_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_raw_temperature,
    input  logic [23:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_temperature_tenths,
    output logic [17:0]        o_pressure_pa,
    output logic               o_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);
    logic [47:0] r_ac123;
    logic [47:0] r_ac456;
    logic [31:0] r_b12;
    logic [31:0] r_mcmd;
    logic [1:0]  r_oss;

    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2, w_mc, w_md;

    assign w_ac1 = psc_pkg::sx16(r_ac123[47:32]);
    assign w_ac2 = psc_pkg::sx16(r_ac123[31:16]);
    assign w_ac3 = psc_pkg::sx16(r_ac123[15:0]);
    assign w_ac4 = {16'd0, r_ac456[47:32]};
    assign w_ac5 = {16'd0, r_ac456[31:16]};
    assign w_ac6 = {16'd0, r_ac456[15:0]};
    assign w_b1  = psc_pkg::sx16(r_b12[31:16]);
    assign w_b2  = psc_pkg::sx16(r_b12[15:0]);
    assign w_mc  = psc_pkg::sx16(r_mcmd[31:16]);
    assign w_md  = psc_pkg::sx16(r_mcmd[15:0]);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b12   <= '0;
            r_mcmd  <= '0;
            r_oss   <= 2'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psc_pkg::CFG_AC123: r_ac123 <= i_cfg_data;
                psc_pkg::CFG_AC456: r_ac456 <= i_cfg_data;
                psc_pkg::CFG_B12:   r_b12   <= i_cfg_data[31:0];
                psc_pkg::CFG_MCMD:  r_mcmd  <= i_cfg_data[31:0];
                psc_pkg::CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage valids and ready chain
    logic [2:0] r_fv;
    logic [4:0] r_mv;
    logic [2:0] r_bv;
    logic [2:0] w_frdy;
    logic [4:0] w_mrdy;
    logic [2:0] w_brdy;
    logic       w_d1_rdy, w_d1_vld, w_d2_rdy, w_d2_vld;
    psc_pkg::t_div w_d1_out, w_d2_in, w_d2_out;

    always_comb begin
        w_brdy[2] = !r_bv[2] || !i_stall;
        w_brdy[1] = !r_bv[1] || w_brdy[2];
        w_brdy[0] = !r_bv[0] || w_brdy[1];
        w_mrdy[4] = !r_mv[4] || w_d2_rdy;
        w_mrdy[3] = !r_mv[3] || w_mrdy[4];
        w_mrdy[2] = !r_mv[2] || w_mrdy[3];
        w_mrdy[1] = !r_mv[1] || w_mrdy[2];
        w_mrdy[0] = !r_mv[0] || w_mrdy[1];
        w_frdy[2] = !r_fv[2] || w_d1_rdy;
        w_frdy[1] = !r_fv[1] || w_frdy[2];
        w_frdy[0] = !r_fv[0] || w_frdy[1];
    end

    assign o_stall = !w_frdy[0];
    assign o_valid = r_bv[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_mv <= '0;
            r_bv <= '0;
        end else begin
            if (w_frdy[0]) r_fv[0] <= i_valid;
            if (w_frdy[1]) r_fv[1] <= r_fv[0];
            if (w_frdy[2]) r_fv[2] <= r_fv[1];
            if (w_mrdy[0]) r_mv[0] <= w_d1_vld;
            if (w_mrdy[1]) r_mv[1] <= r_mv[0];
            if (w_mrdy[2]) r_mv[2] <= r_mv[1];
            if (w_mrdy[3]) r_mv[3] <= r_mv[2];
            if (w_mrdy[4]) r_mv[4] <= r_mv[3];
            if (w_brdy[0]) r_bv[0] <= w_d2_vld;
            if (w_brdy[1]) r_bv[1] <= r_bv[0];
            if (w_brdy[2]) r_bv[2] <= r_bv[1];
        end
    end

    // front stages
    logic [15:0] r0_ut;
    logic [23:0] r0_up;
    logic [31:0] r1_x1, r1_dv;
    logic [23:0] r1_up;
    psc_pkg::t_div r2_div;
    logic [31:0] n1_x1, n1_prod, n2_n;

    always_comb begin
        n1_prod = ({16'd0, r0_ut} - w_ac6) * w_ac5;
        n1_x1   = psc_pkg::asr32(n1_prod, 5'd15);
        n2_n    = w_mc << 11;
    end

    always_ff @(posedge i_clk) begin
        if (w_frdy[0]) begin
            r0_ut <= i_raw_temperature;
            r0_up <= 24'(i_raw_pressure >> (4'd8 - {2'b00, r_oss}));
        end
        if (w_frdy[1]) begin
            r1_x1 <= n1_x1;
            r1_dv <= n1_x1 + w_md;
            r1_up <= r0_up;
        end
        if (w_frdy[2]) begin
            r2_div.rem        <= '0;
            r2_div.num        <= n2_n[31] ? -n2_n : n2_n;
            r2_div.den        <= r1_dv[31] ? -r1_dv : r1_dv;
            r2_div.side.a     <= r1_x1;
            r2_div.side.up    <= r1_up;
            r2_div.side.fault <= (r1_dv == '0);
            r2_div.side.neg   <= n2_n[31] ^ r1_dv[31];
        end
    end

    psc_div u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fv[2]),
        .o_rdy   (w_d1_rdy),
        .i_data  (r2_div),
        .o_vld   (w_d1_vld),
        .i_rdy   (w_mrdy[0]),
        .o_data  (w_d1_out)
    );

    // pressure stages
    logic [31:0] rp1_b5;
    logic [31:0] rp2_sqr, rp2_m2, rp2_m3;
    logic [31:0] rp3_pb1, rp3_pb2, rp3_m2, rp3_m3;
    logic [31:0] rp4_b3, rp4_x3;
    logic [31:0] rp5_b4, rp5_b7;
    logic [15:0] rp2_ts, rp3_ts, rp4_ts, rp5_ts;
    logic [23:0] rp1_up, rp2_up, rp3_up, rp4_up, rp5_up;
    logic [4:0]  rp_flt;

    logic [31:0] n_q1, n_b6, n_t, n_sq, n_xa, n_v, n_b3, n_x3;
    logic [15:0] n_ts;

    always_comb begin
        n_q1 = w_d1_out.side.neg ? -w_d1_out.num : w_d1_out.num;
        n_b6 = rp1_b5 - psc_pkg::B6_OFS;
        n_t  = psc_pkg::asr32(rp1_b5 + 32'd8, 5'd4);
        if ($signed(n_t) > 32'sd32767) begin
            n_ts = 16'h7FFF;
        end else if ($signed(n_t) < -32'sd32768) begin
            n_ts = 16'h8000;
        end else begin
            n_ts = n_t[15:0];
        end
        n_sq = psc_pkg::asr32(rp2_sqr, 5'd12);
        n_xa = psc_pkg::asr32(rp3_pb2, 5'd11) + psc_pkg::asr32(rp3_m2, 5'd11);
        n_v  = (((w_ac1 << 2) + n_xa) << r_oss) + 32'd2;
        n_b3 = psc_pkg::asr32(n_v + (n_v[31] ? 32'd3 : 32'd0), 5'd2);
        n_x3 = psc_pkg::asr32(psc_pkg::asr32(rp3_m3, 5'd13)
                              + psc_pkg::asr32(rp3_pb1, 5'd16) + 32'd2, 5'd2);
    end

    always_ff @(posedge i_clk) begin
        if (w_mrdy[0]) begin
            rp1_b5    <= w_d1_out.side.a + n_q1;
            rp1_up    <= w_d1_out.side.up;
            rp_flt[0] <= w_d1_out.side.fault;
        end
        if (w_mrdy[1]) begin
            rp2_sqr   <= n_b6 * n_b6;
            rp2_m2    <= w_ac2 * n_b6;
            rp2_m3    <= w_ac3 * n_b6;
            rp2_ts    <= n_ts;
            rp2_up    <= rp1_up;
            rp_flt[1] <= rp_flt[0];
        end
        if (w_mrdy[2]) begin
            rp3_pb2   <= w_b2 * n_sq;
            rp3_pb1   <= w_b1 * n_sq;
            rp3_m2    <= rp2_m2;
            rp3_m3    <= rp2_m3;
            rp3_ts    <= rp2_ts;
            rp3_up    <= rp2_up;
            rp_flt[2] <= rp_flt[1];
        end
        if (w_mrdy[3]) begin
            rp4_b3    <= n_b3;
            rp4_x3    <= n_x3;
            rp4_ts    <= rp3_ts;
            rp4_up    <= rp3_up;
            rp_flt[3] <= rp_flt[2];
        end
        if (w_mrdy[4]) begin
            rp5_b4    <= (w_ac4 * (rp4_x3 + psc_pkg::X3_OFS)) >> 15;
            rp5_b7    <= ({8'd0, rp4_up} - rp4_b3) * (psc_pkg::B7_SCALE >> r_oss);
            rp5_ts    <= rp4_ts;
            rp5_up    <= rp4_up;
            rp_flt[4] <= rp_flt[3];
        end
    end

    always_comb begin
        w_d2_in.rem        = '0;
        w_d2_in.num        = rp5_b7[31] ? rp5_b7 : (rp5_b7 << 1);
        w_d2_in.den        = rp5_b4;
        w_d2_in.side.a     = {16'd0, rp5_ts};
        w_d2_in.side.up    = rp5_up;
        w_d2_in.side.fault = rp_flt[4] || (rp5_b4 == '0);
        w_d2_in.side.neg   = rp5_b7[31];
    end

    psc_div u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_mv[4]),
        .o_rdy   (w_d2_rdy),
        .i_data  (w_d2_in),
        .o_vld   (w_d2_vld),
        .i_rdy   (w_brdy[0]),
        .o_data  (w_d2_out)
    );

    // output stages
    logic [31:0] rq1_p, rq1_x1, rq1_x2;
    logic [31:0] rq2_p, rq2_x1, rq2_x2;
    logic [15:0] rq1_ts, rq2_ts;
    logic [1:0]  rq_flt;
    logic signed [15:0] r_temp;
    logic [17:0] r_pres;
    logic        r_fault;
    logic [31:0] n_p, n_ph, n_pf;
    logic [17:0] n_ps;

    always_comb begin
        n_p  = w_d2_out.side.neg ? (w_d2_out.num << 1) : w_d2_out.num;
        n_ph = psc_pkg::asr32(n_p, 5'd8);
        n_pf = rq2_p + psc_pkg::asr32(rq2_x1 + rq2_x2 + psc_pkg::K_OFS, 5'd4);
        if (n_pf[31]) begin
            n_ps = '0;
        end else if (n_pf > {14'd0, psc_pkg::P_MAX}) begin
            n_ps = psc_pkg::P_MAX;
        end else begin
            n_ps = n_pf[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_brdy[0]) begin
            rq1_p     <= n_p;
            rq1_x1    <= n_ph * n_ph;
            rq1_x2    <= psc_pkg::asr32(psc_pkg::K_LIN * n_p, 5'd16);
            rq1_ts    <= w_d2_out.side.a[15:0];
            rq_flt[0] <= w_d2_out.side.fault;
        end
        if (w_brdy[1]) begin
            rq2_p     <= rq1_p;
            rq2_x1    <= psc_pkg::asr32(rq1_x1 * psc_pkg::K_SQ, 5'd16);
            rq2_x2    <= rq1_x2;
            rq2_ts    <= rq1_ts;
            rq_flt[1] <= rq_flt[0];
        end
        if (w_brdy[2]) begin
            r_temp  <= rq_flt[1] ? '0 : rq2_ts;
            r_pres  <= rq_flt[1] ? '0 : n_ps;
            r_fault <= rq_flt[1];
        end
    end

    assign o_temperature_tenths = r_temp;
    assign o_pressure_pa        = r_pres;
    assign o_fault              = r_fault;
endmodule

### design/psc_div_cell.sv
// one restoring division cell: one quotient bit per cycle while i_rdy does not hold it
module psc_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  psc_pkg::t_div   i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output psc_pkg::t_div   o_data
);
    logic            r_vld;
    psc_pkg::t_div   r_data;
    psc_pkg::t_div   n_data;
    logic [32:0]     w_tr;
    logic [32:0]     w_diff;
    logic            w_ge;

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    always_comb begin
        w_tr   = {i_data.rem, i_data.num[31]};
        w_ge   = w_tr >= {1'b0, i_data.den};
        w_diff = w_tr - {1'b0, i_data.den};
        n_data = i_data;
        n_data.rem = w_ge ? w_diff[31:0] : w_tr[31:0];
        n_data.num = {i_data.num[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end
endmodule

### design/psc_div.sv
// unsigned 32 by 32 divider as a row of restoring cells
module psc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  psc_pkg::t_div   i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output psc_pkg::t_div   o_data
);
    psc_pkg::t_div w_d   [psc_pkg::DIV_W+1];
    logic          w_v   [psc_pkg::DIV_W+1];
    logic          w_rdy [psc_pkg::DIV_W+1];

    assign w_d[0]                = i_data;
    assign w_v[0]                = i_vld;
    assign o_rdy                 = w_rdy[0];
    assign w_rdy[psc_pkg::DIV_W] = i_rdy;
    assign o_vld                 = w_v[psc_pkg::DIV_W];
    assign o_data                = w_d[psc_pkg::DIV_W];

    for (genvar k = 0; k < psc_pkg::DIV_W; k++) begin : g_cell
        psc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_v[k]),
            .o_rdy   (w_rdy[k]),
            .i_data  (w_d[k]),
            .o_vld   (w_v[k+1]),
            .i_rdy   (w_rdy[k+1]),
            .o_data  (w_d[k+1])
        );
    end
endmodule

### design/psc_checker.sv
// port-level checks for the compensation block, bound to the top level
`include "pressure_sensor_compensation_top_macros.svh"

module psc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_temperature_tenths,
    input logic [17:0]        o_pressure_pa,
    input logic               o_fault
);
    `PSC_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n, o_valid && o_fault, o_temperature_tenths == 16'sd0 && o_pressure_pa == 18'd0)
    `PSC_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `PSC_ASSERT_NXT(a_valid_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `PSC_ASSERT_NXT(a_data_holds, i_clk, i_rst_n, o_valid && i_stall, $stable(o_pressure_pa) && $stable(o_fault))
endmodule

bind pressure_sensor_compensation_top psc_checker u_psc_checker (.*);

### tb/tb_pressure_sensor_compensation_top.sv
// self-checking testbench for the pressure and temperature compensation pipeline
`timescale 1ns / 100ps

module tb_pressure_sensor_compensation_top;

    typedef struct {
        logic [15:0] raw_t;
        logic [23:0] raw_p;
    } t_sample;

    typedef struct {
        logic signed [15:0] temp;
        logic [17:0]        pa;
        logic               flt;
    } t_reading;

    localparam int WATCHDOG_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [15:0]        i_raw_temperature = '0;
    logic [23:0]        i_raw_pressure = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_temperature_tenths;
    logic [17:0]        o_pressure_pa;
    logic               o_fault;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [47:0]        i_cfg_data = '0;

    logic [47:0] cal_ac123 = '0;
    logic [47:0] cal_ac456 = '0;
    logic [31:0] cal_b12 = '0;
    logic [31:0] cal_mcmd = '0;
    logic [1:0]  cal_oss = 2'd1;

    t_sample  sample_q[$];
    t_reading reading_q[$];
    int       gap_cnt = 0;
    int       stall_cnt = 0;
    bit       burst = 1'b0;
    int       err_cnt = 0;
    int       quiet_cycles = 0;

    pressure_sensor_compensation_top dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sext(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] quot_trunc(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] un;
        logic [31:0] ud;
        logic [31:0] q;
        un = n[31] ? -n : n;
        ud = d[31] ? -d : d;
        q = un / ud;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic t_reading compensate(input t_sample s);
        t_reading r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, dv;
        ac1 = sext(cal_ac123[47:32]);
        ac2 = sext(cal_ac123[31:16]);
        ac3 = sext(cal_ac123[15:0]);
        ac4 = {16'd0, cal_ac456[47:32]};
        ac5 = {16'd0, cal_ac456[31:16]};
        ac6 = {16'd0, cal_ac456[15:0]};
        b1 = sext(cal_b12[31:16]);
        b2 = sext(cal_b12[15:0]);
        mc = sext(cal_mcmd[31:16]);
        md = sext(cal_mcmd[15:0]);
        ut = {16'd0, s.raw_t};
        up = {8'd0, s.raw_p} >> (8 - cal_oss);
        r.temp = '0;
        r.pa = '0;
        r.flt = 1'b1;
        x1 = sra((ut - ac6) * ac5, 15);
        dv = x1 + md;
        if (dv == 0) return r;
        x2 = quot_trunc(mc << 11, dv);
        b5 = x1 + x2;
        t = sra(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = sra(b6 * b6, 12);
        x1 = sra(b2 * sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = quot_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (32'd50000 >> cal_oss);
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(-32'd7357 * p, 16);
        p = p + sra(x1 + x2 + 32'd3791, 4);
        if ($signed(t) > 32767) r.temp = 16'sh7FFF;
        else if ($signed(t) < -32768) r.temp = 16'sh8000;
        else r.temp = t[15:0];
        if ($signed(p) < 0) r.pa = '0;
        else if ($signed(p) > 262143) r.pa = 18'h3FFFF;
        else r.pa = p[17:0];
        r.flt = 1'b0;
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                reading_q.push_back(compensate('{i_raw_temperature, i_raw_pressure}));
            end
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                i_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                t_sample s;
                s = sample_q.pop_front();
                i_raw_temperature <= s.raw_t;
                i_raw_pressure <= s.raw_p;
                i_valid <= 1'b1;
                gap_cnt <= burst ? 0 : $urandom_range(0, 4);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                int n;
                if (reading_q.size() == 0) begin
                    $error("result with nothing expected");
                    err_cnt++;
                end else begin
                    t_reading e;
                    e = reading_q.pop_front();
                    if (o_temperature_tenths !== e.temp) begin
                        $error("temperature_tenths expected %0d actual %0d",
                               e.temp, o_temperature_tenths);
                        err_cnt++;
                    end
                    if (o_pressure_pa !== e.pa) begin
                        $error("pressure_pa expected %0d actual %0d", e.pa, o_pressure_pa);
                        err_cnt++;
                    end
                    if (o_fault !== e.flt) begin
                        $error("fault expected %0d actual %0d", e.flt, o_fault);
                        err_cnt++;
                    end
                end
                n = burst ? 0 : $urandom_range(0, 4);
                stall_cnt <= n;
                i_stall <= (n != 0);
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_stall <= (stall_cnt > 1);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (sample_q.size() == 0 && reading_q.size() == 0 && !i_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pressure_sensor_compensation_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            psc_pkg::CFG_AC123: cal_ac123 = val;
            psc_pkg::CFG_AC456: cal_ac456 = val;
            psc_pkg::CFG_B12:   cal_b12 = val[31:0];
            psc_pkg::CFG_MCMD:  cal_mcmd = val[31:0];
            psc_pkg::CFG_OSS:   cal_oss = val[1:0];
            default: ;
        endcase
    endtask

    task automatic calibrate(input logic [47:0] a123, input logic [47:0] a456,
                             input logic [31:0] b12, input logic [31:0] mcmd,
                             input logic [1:0] oss);
        write_reg(psc_pkg::CFG_AC123, a123);
        write_reg(psc_pkg::CFG_AC456, a456);
        write_reg(psc_pkg::CFG_B12, {16'd0, b12});
        write_reg(psc_pkg::CFG_MCMD, {16'd0, mcmd});
        write_reg(psc_pkg::CFG_OSS, {46'd0, oss});
    endtask

    task automatic drain;
        wait (sample_q.size() == 0 && !i_valid && reading_q.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rnd48();
        return {16'($urandom), $urandom};
    endfunction

    initial begin
        logic [47:0] ds_ac123;
        logic [47:0] ds_ac456;
        logic [31:0] ds_b12;
        logic [31:0] ds_mcmd;
        ds_ac123 = {16'sd408, -16'sd72, -16'sd14383};
        ds_ac456 = {16'd32741, 16'd32757, 16'd23153};
        ds_b12 = {16'sd6190, 16'sd4};
        ds_mcmd = {-16'sd8711, 16'sd2868};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: temperature and pressure divisors are both zero
        sample_q.push_back('{16'd27898, 24'h5D_2300});
        drain();

        // datasheet calibration across all oversampling settings and field extremes
        for (int o = 0; o < 4; o++) begin
            calibrate(ds_ac123, ds_ac456, ds_b12, ds_mcmd, o[1:0]);
            sample_q.push_back('{16'd27898, 24'd23843 << (8 - o)});
            sample_q.push_back('{16'd0, 24'd0});
            sample_q.push_back('{16'hFFFF, 24'hFFFFFF});
            sample_q.push_back('{16'd0, 24'hFFFFFF});
            drain();
        end

        // zero temperature divisor
        calibrate(ds_ac123, {16'd32741, 16'd0, 16'd23153}, ds_b12, {-16'sd8711, 16'sd0}, 2'd1);
        sample_q.push_back('{16'd27898, 24'h123456});
        drain();
        // zero pressure divisor
        calibrate(ds_ac123, {16'd0, 16'd32757, 16'd23153}, ds_b12, ds_mcmd, 2'd3);
        sample_q.push_back('{16'd27898, 24'h123456});
        drain();
        // all-ones and all-zero coefficient extremes, the latter with md set to one
        calibrate({48{1'b1}}, {48{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        sample_q.push_back('{16'hFFFF, 24'hFFFFFF});
        sample_q.push_back('{16'd0, 24'd0});
        drain();
        calibrate('0, '0, '0, 32'h0000_0001, 2'd0);
        sample_q.push_back('{16'h8000, 24'h800000});
        drain();

        // random phases: mostly near-datasheet calibration, some fully random
        for (int ph = 0; ph < 10; ph++) begin
            burst = (ph % 3 == 2);
            if (ph % 4 == 3) begin
                calibrate(rnd48(), rnd48(), $urandom, $urandom, 2'($urandom_range(0, 3)));
            end else begin
                calibrate(ds_ac123 ^ 48'(rnd48() & 48'h00FF_00FF_00FF),
                          ds_ac456 ^ 48'(rnd48() & 48'h01FF_01FF_01FF),
                          ds_b12 ^ ($urandom & 32'h00FF_000F),
                          ds_mcmd ^ ($urandom & 32'h00FF_00FF),
                          2'($urandom_range(0, 3)));
            end
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(0, 3) == 0)
                    sample_q.push_back('{16'($urandom), 24'($urandom)});
                else
                    sample_q.push_back('{16'($urandom_range(20000, 36000)),
                                         24'($urandom_range(20000, 40000) << (8 - cal_oss))
                                         ^ 24'($urandom_range(0, 255))});
            end
            drain();
        end
        burst = 1'b0;

        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("pressure_sensor_compensation_top verification clean");
        end else begin
            $display("pressure_sensor_compensation_top verification failed");
        end
        $finish;
    end

endmodule
